// ===== rtl/psrt_pkg.sv =====
package psrt_pkg;

	// Default fraction widths
	localparam int COEF_FRAC_BITS_DEF  = 16;
	localparam int COORD_FRAC_BITS_DEF = 16;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE   = 3'd0,
		REG_ANGLE_X = 3'd1,
		REG_ANGLE_Y = 3'd2,
		REG_ANGLE_Z = 3'd3,
		REG_SHIFT_X = 3'd4,
		REG_SHIFT_Y = 3'd5,
		REG_SHIFT_Z = 3'd6
	} cfg_reg_t;

	// Register reset values
	localparam logic [7:0]         SCALE_RST   = 8'd1;
	localparam logic signed [15:0] SHIFT_X_RST = 16'sd300;
	localparam logic signed [15:0] SHIFT_Y_RST = 16'sd400;
	localparam logic signed [15:0] SHIFT_Z_RST = 16'sd0;

	// Angle folding
	localparam logic [9:0] DEG_90  = 10'd90;
	localparam logic [9:0] DEG_180 = 10'd180;
	localparam logic [9:0] DEG_270 = 10'd270;
	localparam logic [9:0] DEG_360 = 10'd360;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] new_x;
		logic signed [31:0] new_y;
		logic signed [31:0] new_z;
		logic signed [15:0] pixel_x;
		logic signed [15:0] pixel_y;
		logic               overflow;
	} out_item_t;

	// Quarter-wave sine, Q1.16, one entry per degree
	function automatic logic [16:0] sine_q16(input logic [6:0] d);
		logic [16:0] v;
		case (d)
			7'd0: v = 17'd0;      7'd1: v = 17'd1144;   7'd2: v = 17'd2287;
			7'd3: v = 17'd3430;   7'd4: v = 17'd4572;   7'd5: v = 17'd5712;
			7'd6: v = 17'd6850;   7'd7: v = 17'd7987;   7'd8: v = 17'd9121;
			7'd9: v = 17'd10252;  7'd10: v = 17'd11380; 7'd11: v = 17'd12505;
			7'd12: v = 17'd13626; 7'd13: v = 17'd14742; 7'd14: v = 17'd15855;
			7'd15: v = 17'd16962; 7'd16: v = 17'd18064; 7'd17: v = 17'd19161;
			7'd18: v = 17'd20252; 7'd19: v = 17'd21336; 7'd20: v = 17'd22415;
			7'd21: v = 17'd23486; 7'd22: v = 17'd24550; 7'd23: v = 17'd25607;
			7'd24: v = 17'd26656; 7'd25: v = 17'd27697; 7'd26: v = 17'd28729;
			7'd27: v = 17'd29753; 7'd28: v = 17'd30767; 7'd29: v = 17'd31772;
			7'd30: v = 17'd32768; 7'd31: v = 17'd33754; 7'd32: v = 17'd34729;
			7'd33: v = 17'd35693; 7'd34: v = 17'd36647; 7'd35: v = 17'd37590;
			7'd36: v = 17'd38521; 7'd37: v = 17'd39441; 7'd38: v = 17'd40348;
			7'd39: v = 17'd41243; 7'd40: v = 17'd42126; 7'd41: v = 17'd42995;
			7'd42: v = 17'd43852; 7'd43: v = 17'd44695; 7'd44: v = 17'd45525;
			7'd45: v = 17'd46341; 7'd46: v = 17'd47143; 7'd47: v = 17'd47930;
			7'd48: v = 17'd48703; 7'd49: v = 17'd49461; 7'd50: v = 17'd50203;
			7'd51: v = 17'd50931; 7'd52: v = 17'd51643; 7'd53: v = 17'd52339;
			7'd54: v = 17'd53020; 7'd55: v = 17'd53684; 7'd56: v = 17'd54332;
			7'd57: v = 17'd54963; 7'd58: v = 17'd55578; 7'd59: v = 17'd56175;
			7'd60: v = 17'd56756; 7'd61: v = 17'd57319; 7'd62: v = 17'd57865;
			7'd63: v = 17'd58393; 7'd64: v = 17'd58903; 7'd65: v = 17'd59396;
			7'd66: v = 17'd59870; 7'd67: v = 17'd60326; 7'd68: v = 17'd60764;
			7'd69: v = 17'd61183; 7'd70: v = 17'd61584; 7'd71: v = 17'd61966;
			7'd72: v = 17'd62328; 7'd73: v = 17'd62672; 7'd74: v = 17'd62997;
			7'd75: v = 17'd63303; 7'd76: v = 17'd63589; 7'd77: v = 17'd63856;
			7'd78: v = 17'd64104; 7'd79: v = 17'd64332; 7'd80: v = 17'd64540;
			7'd81: v = 17'd64729; 7'd82: v = 17'd64898; 7'd83: v = 17'd65048;
			7'd84: v = 17'd65177; 7'd85: v = 17'd65287; 7'd86: v = 17'd65376;
			7'd87: v = 17'd65446; 7'd88: v = 17'd65496; 7'd89: v = 17'd65526;
			7'd90: v = 17'd65536;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/point_scale_rotate_translate_core.sv =====
// Point transform: each item is a signed 3D point with COORD_FRAC_BITS fraction
// bits; it is scaled by scale_factor, rotated by Rx*Ry*Rz and translated, and
// comes out with its truncated pixel X/Y and a saturation flag. The datapath is
// a four-stage pipeline (scale, matrix multiply, row sum and translate, pixel)
// that takes one item per cycle while neither out_stall nor a matrix rebuild
// holds the input. Writing an angle register starts the coefficient sequencer,
// which rebuilds the matrix (sine/cosine lookup, pairwise products, commit); the
// input is stalled from the cycle of the write until the new matrix is committed.
module point_scale_rotate_translate_core import psrt_pkg::*; #(
	parameter int COEF_FRAC_BITS  = COEF_FRAC_BITS_DEF,
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CW = COEF_FRAC_BITS + 2;

	logic [7:0]         scale_q;
	logic [8:0]         ang_x_q, ang_y_q, ang_z_q;
	logic signed [15:0] shift_x_q, shift_y_q, shift_z_q;
	logic               angle_wr;
	logic               busy;
	logic [9*CW-1:0]    coef;

	assign angle_wr = cfg_we && (cfg_index == REG_ANGLE_X || cfg_index == REG_ANGLE_Y
		|| cfg_index == REG_ANGLE_Z);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q   <= SCALE_RST;
			ang_x_q   <= '0;
			ang_y_q   <= '0;
			ang_z_q   <= '0;
			shift_x_q <= SHIFT_X_RST;
			shift_y_q <= SHIFT_Y_RST;
			shift_z_q <= SHIFT_Z_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCALE:   scale_q   <= cfg_data[7:0];
				REG_ANGLE_X: ang_x_q   <= cfg_data[8:0];
				REG_ANGLE_Y: ang_y_q   <= cfg_data[8:0];
				REG_ANGLE_Z: ang_z_q   <= cfg_data[8:0];
				REG_SHIFT_X: shift_x_q <= cfg_data;
				REG_SHIFT_Y: shift_y_q <= cfg_data;
				REG_SHIFT_Z: shift_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	psrt_coef #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_coef (
		.clk   (clk),
		.arst_n(arst_n),
		.start (angle_wr),
		.ang_x (ang_x_q),
		.ang_y (ang_y_q),
		.ang_z (ang_z_q),
		.coef  (coef),
		.busy  (busy)
	);

	psrt_pipe #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS),
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.hold     (busy || angle_wr),
		.scale    (scale_q),
		.shift_x  (shift_x_q),
		.shift_y  (shift_y_q),
		.shift_z  (shift_z_q),
		.coef     (coef),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	// An angle write must hold off items until the matrix is rebuilt
	a_angle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		angle_wr |=> in_stall)
		else $error("item accepted while matrix rebuilds");

	// The sequencer drops busy once it has run its steps after the last angle write
	a_seq_done: assert property (@(posedge clk) disable iff (!arst_n)
		angle_wr ##1 !angle_wr ##1 !angle_wr ##1 !angle_wr |=> !busy)
		else $error("coefficient sequencer did not finish");

	// An accepted item passes the scale, multiply, row-sum and pixel stages to the output when nothing stalls
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall
		|=> out_valid)
		else $error("item lost in pipeline");

endmodule

// ===== rtl/psrt_coef.sv =====
module psrt_coef import psrt_pkg::*; #(
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [8:0]                       ang_x,
	input  logic [8:0]                       ang_y,
	input  logic [8:0]                       ang_z,
	output logic [9*(COEF_FRAC_BITS+2)-1:0]  coef,
	output logic                             busy
);

	localparam int F  = COEF_FRAC_BITS;
	localparam int CW = F + 2;
	localparam int UP = (F >= 16) ? F - 16 : 0;
	localparam int DN = (F < 16) ? 16 - F : 1;
	localparam logic signed [CW-1:0] ONE = CW'(1) <<< F;

	// Table value brought to F fraction bits, sign from quadrant
	function automatic logic signed [CW-1:0] sin_deg(input logic [9:0] d);
		logic [6:0]  idx;
		logic        neg;
		logic [40:0] t;
		logic [CW-1:0] mag;
		if (d <= DEG_90) begin
			idx = d[6:0];
			neg = 1'b0;
		end else if (d <= DEG_180) begin
			idx = 7'(DEG_180 - d);
			neg = 1'b0;
		end else if (d <= DEG_270) begin
			idx = 7'(d - DEG_180);
			neg = 1'b1;
		end else begin
			idx = 7'(DEG_360 - d);
			neg = 1'b1;
		end
		if (F >= 16)
			t = {24'd0, sine_q16(idx)} << UP;
		else
			t = ({24'd0, sine_q16(idx)} + (41'd1 << (DN - 1))) >> DN;
		mag = t[CW-1:0];
		return neg ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic logic [9:0] fold(input logic [8:0] a);
		logic [9:0] d;
		d = {1'b0, a};
		return (d >= DEG_360) ? d - DEG_360 : d;
	endfunction

	function automatic logic [9:0] quarter(input logic [9:0] d);
		logic [9:0] c;
		c = d + DEG_90;
		return (c >= DEG_360) ? c - DEG_360 : c;
	endfunction

	// Rounded Q2.F product
	function automatic logic signed [CW:0] mulc(input logic signed [CW:0] a,
			input logic signed [CW:0] b);
		logic signed [2*CW+1:0] p;
		p = a * b + ((2*CW+2)'(1) <<< (F - 1));
		return (CW+1)'(p >>> F);
	endfunction

	logic signed [CW:0] sx_q, cx_q, sy_q, cy_q, sz_q, cz_q;
	logic signed [CW:0] sxsy_q, cxsy_q, cycz_q, cysz_q, cxsz_q, cxcz_q;
	logic signed [CW:0] sxsz_q, sxcz_q, sxcy_q, cxcy_q, sy2_q, sz2_q, cz2_q;
	logic signed [CW-1:0] r_q [9];
	logic [1:0] cnt_q;

	// Look up sine and cosine of the folded angles
	always_ff @(posedge clk) begin
		sx_q <= (CW+1)'(sin_deg(fold(ang_x)));
		cx_q <= (CW+1)'(sin_deg(quarter(fold(ang_x))));
		sy_q <= (CW+1)'(sin_deg(fold(ang_y)));
		cy_q <= (CW+1)'(sin_deg(quarter(fold(ang_y))));
		sz_q <= (CW+1)'(sin_deg(fold(ang_z)));
		cz_q <= (CW+1)'(sin_deg(quarter(fold(ang_z))));
	end

	// Form the pairwise products
	always_ff @(posedge clk) begin
		sxsy_q <= mulc(sx_q, sy_q);
		cxsy_q <= mulc(cx_q, sy_q);
		cycz_q <= mulc(cy_q, cz_q);
		cysz_q <= mulc(cy_q, sz_q);
		cxsz_q <= mulc(cx_q, sz_q);
		cxcz_q <= mulc(cx_q, cz_q);
		sxsz_q <= mulc(sx_q, sz_q);
		sxcz_q <= mulc(sx_q, cz_q);
		sxcy_q <= mulc(sx_q, cy_q);
		cxcy_q <= mulc(cx_q, cy_q);
		sy2_q  <= sy_q;
		sz2_q  <= sz_q;
		cz2_q  <= cz_q;
	end

	// Sequence the three steps and commit the matrix on the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			for (int k = 0; k < 9; k++)
				r_q[k] <= (k == 0 || k == 4 || k == 8) ? ONE : '0;
		end else begin
			if (start)
				cnt_q <= 2'd3;
			else if (cnt_q != 2'd0)
				cnt_q <= cnt_q - 2'd1;
			if (!start && cnt_q == 2'd1) begin
				r_q[0] <= CW'(cycz_q);
				r_q[1] <= CW'(-cysz_q);
				r_q[2] <= CW'(sy2_q);
				r_q[3] <= CW'(cxsz_q + mulc(sxsy_q, cz2_q));
				r_q[4] <= CW'(cxcz_q - mulc(sxsy_q, sz2_q));
				r_q[5] <= CW'(-sxcy_q);
				r_q[6] <= CW'(sxsz_q - mulc(cxsy_q, cz2_q));
				r_q[7] <= CW'(sxcz_q + mulc(cxsy_q, sz2_q));
				r_q[8] <= CW'(cxcy_q);
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 9; k++)
			coef[k*CW +: CW] = r_q[k];
	end

	assign busy = (cnt_q != 2'd0);

endmodule

// ===== rtl/psrt_pipe.sv =====
module psrt_pipe import psrt_pkg::*; #(
	parameter int COEF_FRAC_BITS  = COEF_FRAC_BITS_DEF,
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  in_item_t                        in_data,
	input  logic                            hold,
	input  logic [7:0]                      scale,
	input  logic signed [15:0]              shift_x,
	input  logic signed [15:0]              shift_y,
	input  logic signed [15:0]              shift_z,
	input  logic [9*(COEF_FRAC_BITS+2)-1:0] coef,
	output logic                            out_valid,
	input  logic                            out_stall,
	output out_item_t                       out_data
);

	localparam int F  = COEF_FRAC_BITS;
	localparam int C  = COORD_FRAC_BITS;
	localparam int CW = F + 2;
	localparam int PW = CW + 32;
	localparam int AW = PW + 2;
	localparam logic signed [AW-1:0] MAX32 = AW'(64'sd2147483647);
	localparam logic signed [AW-1:0] MIN32 = -AW'(64'sd2147483648);
	localparam logic signed [32:0] MAX16 = 33'sd32767;
	localparam logic signed [32:0] MIN16 = -33'sd32768;
	localparam logic signed [32:0] PBIAS = (33'sd1 <<< C) - 33'sd1;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic en1, en2, en3, en4;
	logic signed [31:0] p_s1 [3];
	logic               ovf_s1;
	logic signed [PW-1:0] prod_s2 [9];
	logic               ovf_s2;
	logic signed [31:0] q_s3 [3];
	logic               ovf_s3;
	out_item_t          out_s4;

	logic signed [31:0] pos [3];
	logic signed [15:0] sh [3];
	logic signed [40:0] sc [3];
	logic signed [31:0] sc_sat [3];
	logic [2:0]         sc_ovf;
	logic signed [AW-1:0] tot [3];
	logic signed [31:0] q_sat [3];
	logic [2:0]         q_ovf;
	logic signed [32:0] pq [2];
	logic signed [15:0] pix [2];
	logic [1:0]         pix_ovf;

	// Advance a stage when the next one is empty or moving
	assign en4 = !vld_s4 || !out_stall;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;
	assign in_stall = hold || !en1;

	assign pos[0] = in_data.pos_x;
	assign pos[1] = in_data.pos_y;
	assign pos[2] = in_data.pos_z;
	assign sh[0] = shift_x;
	assign sh[1] = shift_y;
	assign sh[2] = shift_z;

	// Scale and saturate
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sc[i] = 41'(pos[i]) * $signed({33'd0, scale});
			sc_ovf[i] = (sc[i] > 41'sd2147483647) || (sc[i] < -41'sd2147483648);
			if (sc[i] > 41'sd2147483647)
				sc_sat[i] = 32'sh7fffffff;
			else if (sc[i] < -41'sd2147483648)
				sc_sat[i] = 32'sh80000000;
			else
				sc_sat[i] = sc[i][31:0];
		end
	end

	// Sum each row, round, translate and saturate
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tot[i] = ((AW'(prod_s2[3*i]) + AW'(prod_s2[3*i+1]) + AW'(prod_s2[3*i+2])
				+ (AW'(1) <<< (F - 1))) >>> F) + (AW'(sh[i]) <<< C);
			q_ovf[i] = (tot[i] > MAX32) || (tot[i] < MIN32);
			if (tot[i] > MAX32)
				q_sat[i] = 32'sh7fffffff;
			else if (tot[i] < MIN32)
				q_sat[i] = 32'sh80000000;
			else
				q_sat[i] = tot[i][31:0];
		end
	end

	// Drop the fraction toward zero and saturate to pixel range
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			pq[i] = (q_s3[i] < 0) ? (33'(q_s3[i]) + PBIAS) >>> C : 33'(q_s3[i]) >>> C;
			pix_ovf[i] = (pq[i] > MAX16) || (pq[i] < MIN16);
			if (pq[i] > MAX16)
				pix[i] = 16'sh7fff;
			else if (pq[i] < MIN16)
				pix[i] = 16'sh8000;
			else
				pix[i] = pq[i][15:0];
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid && !in_stall;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
		end
	end

	// Payload stages
	always_ff @(posedge clk) begin
		if (en1) begin
			for (int i = 0; i < 3; i++)
				p_s1[i] <= sc_sat[i];
			ovf_s1 <= |sc_ovf;
		end
		if (en2) begin
			for (int k = 0; k < 9; k++)
				prod_s2[k] <= $signed(coef[k*CW +: CW]) * p_s1[k % 3];
			ovf_s2 <= ovf_s1;
		end
		if (en3) begin
			for (int i = 0; i < 3; i++)
				q_s3[i] <= q_sat[i];
			ovf_s3 <= ovf_s2 || (|q_ovf);
		end
		if (en4) begin
			out_s4.new_x    <= q_s3[0];
			out_s4.new_y    <= q_s3[1];
			out_s4.new_z    <= q_s3[2];
			out_s4.pixel_x  <= pix[0];
			out_s4.pixel_y  <= pix[1];
			out_s4.overflow <= ovf_s3 || (|pix_ovf);
		end
	end

	assign out_valid = vld_s4;
	assign out_data  = out_s4;

endmodule
